// ===== hw/rtl/hht_pkg.sv =====
// ----------------------------------------------------------------------------
// hht_pkg
// Shared types and constants for the HTTP header tokenizer.
// ----------------------------------------------------------------------------
package hht_pkg;

	localparam int unsigned SPAN_W = 12;

	localparam logic [SPAN_W-1:0] SPAN_RESET = 12'd255;
	localparam logic [SPAN_W-1:0] SPAN_MAX   = 12'hFFF;

	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SPACE = 8'h20;

	typedef enum logic [1:0] {
		ROLE_DELIM = 2'd0,
		ROLE_KEY   = 2'd1,
		ROLE_VALUE = 2'd2,
		ROLE_BODY  = 2'd3
	} role_t;

	typedef enum logic [2:0] {
		STAT_OK         = 3'd0,
		STAT_KEY_BREAK  = 3'd1,
		STAT_NO_SPACE   = 3'd2,
		STAT_VALUE_LONG = 3'd3,
		STAT_CR_NO_LF   = 3'd4,
		STAT_END_NO_LF  = 3'd5
	} status_t;

	typedef enum logic [8:0] {
		PS_START  = 9'b000000001,
		PS_KEY    = 9'b000000010,
		PS_COLON  = 9'b000000100,
		PS_SPACE  = 9'b000001000,
		PS_VALUE  = 9'b000010000,
		PS_CR     = 9'b000100000,
		PS_LF     = 9'b001000000,
		PS_END_CR = 9'b010000000,
		PS_END_LF = 9'b100000000
	} parse_state_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       start_of_message;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [1:0] byte_role;
		logic       pair_done;
		logic       headers_done;
		logic [2:0] status;
	} out_item_t;

	// Parser context carried from one byte to the next.
	typedef struct packed {
		parse_state_t      state;
		logic [SPAN_W-1:0] value_offset;
		status_t           error_code;
	} ctx_t;

	localparam ctx_t CTX_RESET = '{state: PS_START, value_offset: '0, error_code: STAT_OK};

endpackage

// ===== hw/rtl/hht_step.sv =====
// ----------------------------------------------------------------------------
// hht_step
// Next-state and result logic for one byte of the header block.
// ----------------------------------------------------------------------------
module hht_step (
	input  hht_pkg::ctx_t                    ctx,
	input  hht_pkg::in_item_t                item,
	input  logic [hht_pkg::SPAN_W-1:0]       max_span,
	output hht_pkg::ctx_t                    ctx_next,
	output hht_pkg::out_item_t               result
);
	import hht_pkg::*;

	ctx_t              cur;
	ctx_t              nxt;
	role_t             role;
	logic              pair;
	logic              hdone;
	logic [SPAN_W:0]   offset_inc;
	logic [7:0]        b;

	assign b          = item.data_byte;
	assign offset_inc = {1'b0, cur.value_offset} + {{SPAN_W{1'b0}}, 1'b1};

	always_comb begin
		cur   = item.start_of_message ? CTX_RESET : ctx;
		nxt   = cur;
		role  = ROLE_DELIM;
		pair  = 1'b0;
		hdone = 1'b0;
		if (cur.error_code == STAT_OK) begin
			unique case (cur.state)
				PS_KEY: begin
					if (b == CH_COLON) begin
						nxt.state = PS_COLON;
					end else if (b == CH_CR || b == CH_LF) begin
						nxt.error_code = STAT_KEY_BREAK;
					end else begin
						role = ROLE_KEY;
					end
				end
				PS_COLON: begin
					if (b == CH_SPACE) begin
						nxt.state = PS_SPACE;
					end else begin
						nxt.error_code = STAT_NO_SPACE;
					end
				end
				PS_SPACE: begin
					// first value byte, whatever it is
					nxt.state        = PS_VALUE;
					nxt.value_offset = '0;
					role             = ROLE_VALUE;
				end
				PS_VALUE: begin
					if (b == CH_CR) begin
						nxt.state = PS_CR;
					end else begin
						nxt.value_offset = offset_inc[SPAN_W] ? SPAN_MAX
							: offset_inc[SPAN_W-1:0];
						if (offset_inc > {1'b0, max_span}) begin
							nxt.error_code = STAT_VALUE_LONG;
						end else begin
							role = ROLE_VALUE;
						end
					end
				end
				PS_CR: begin
					if (b == CH_LF) begin
						nxt.state = PS_LF;
						pair      = 1'b1;
					end else begin
						nxt.error_code = STAT_CR_NO_LF;
					end
				end
				PS_LF: begin
					if (b == CH_CR) begin
						nxt.state = PS_END_CR;
					end else begin
						nxt.state = PS_KEY;
						role      = ROLE_KEY;
					end
				end
				PS_END_CR: begin
					if (b == CH_LF) begin
						nxt.state = PS_END_LF;
						hdone     = 1'b1;
					end else begin
						nxt.error_code = STAT_END_NO_LF;
					end
				end
				PS_END_LF: begin
					role = ROLE_BODY;
				end
				default: begin
					// start state; skip leading line breaks
					if (b != CH_CR && b != CH_LF) begin
						nxt.state = PS_KEY;
						role      = ROLE_KEY;
					end else begin
						nxt.state = PS_START;
					end
				end
			endcase
		end
	end

	assign ctx_next            = nxt;
	assign result.out_byte     = b;
	assign result.byte_role    = role;
	assign result.pair_done    = pair;
	assign result.headers_done = hdone;
	assign result.status       = nxt.error_code;

endmodule

// ===== hw/rtl/http_header_tokenizer.sv =====
// ----------------------------------------------------------------------------
// http_header_tokenizer
// Streaming HTTP request header tokenizer, one byte per clock unless stalled.
// ----------------------------------------------------------------------------
//
//  channel | signals                          | direction | moves
//  --------+----------------------------------+-----------+---------------------
//  in      | in_valid, in_ready, in_data      | input     | one raw byte request
//  out     | out_valid, out_ready, out_data   | output    | one tagged byte
//  cfg     | cfg_valid, cfg_ready, cfg_data   | input     | max_value_span write
//
// One byte per clock sustained while the output is not stalled. The result
// passes through the input register, then the parser step into the result
// register. The throughput is set by the parser context loop.
// Reset clears the parser context, both stage valid flags and loads the
// value span limit with 255. A stalled output holds its result; the input
// register still fills, and the stage advances when the result is taken.
// ----------------------------------------------------------------------------
module http_header_tokenizer (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  hht_pkg::in_item_t            in_data,
	output logic                         out_valid,
	input  logic                         out_ready,
	output hht_pkg::out_item_t           out_data,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [hht_pkg::SPAN_W-1:0]   cfg_data
);
	import hht_pkg::*;

	// input stage
	in_item_t          item_s1;
	logic              valid_s1;
	// result stage
	out_item_t         result_s2;
	logic              valid_s2;
	// parser context and limit
	ctx_t              ctx_q;
	logic [SPAN_W-1:0] max_span_q;

	ctx_t              ctx_next;
	out_item_t         step_result;
	logic              advance;

	// Advance the parser when a byte waits and the result slot is free or
	// being drained this cycle.
	assign advance   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;
	assign out_valid = valid_s2;
	assign out_data  = result_s2;

	hht_step u_step (
		.ctx      (ctx_q),
		.item     (item_s1),
		.max_span (max_span_q),
		.ctx_next (ctx_next),
		.result   (step_result)
	);

	// Hold the limit; write it from the config request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_span_q <= SPAN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			max_span_q <= cfg_data;
		end
	end

	// Input stage control and payload.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	// Parser context; update only when a byte is consumed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctx_q <= CTX_RESET;
		end else if (advance) begin
			ctx_q <= ctx_next;
		end
	end

	// Result stage: load on advance, drop valid once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= step_result;
		end
	end

endmodule
